// ----- src/rra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rra_pkg: shared types and constants for the refrigeration relay arbiter
// Holds the beat payload structs, register indexes, reset values and the
// decision bit positions used by every module of the block.
// ----------------------------------------------------------------------------
package rra_pkg;

  // Field widths.
  localparam int ELAPSED_W = 20;
  localparam int DT_W      = 16;
  localparam int CFG_IDX_W = 8;
  localparam int DEC_W     = 5;

  // Saturation limit of the compressor-state timer.
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 20'd999999;

  // Register reset values.
  localparam logic [ELAPSED_W-1:0] MIN_OFF_RST = 20'd180000;
  localparam logic [ELAPSED_W-1:0] MIN_ON_RST  = 20'd120000;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON  = 8'd1;

  // Operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SAFE = 1'b1;

  // Decision bit positions, same order as the defrost requests.
  localparam int BIT_COMP   = 0;
  localparam int BIT_HEATER = 1;
  localparam int BIT_EVAP   = 2;
  localparam int BIT_COND   = 3;
  localparam int BIT_HGAS   = 4;

  // Input beat payload.
  typedef struct packed {
    logic            op;
    logic [DT_W-1:0] dt_ms;
    logic [2:0]      therm_requests;
    logic            defrost_mode;
    logic [4:0]      defrost_requests;
    logic            lockout_req;
    logic            comp_feedback;
  } rra_in_t;

  // Result beat payload.
  typedef struct packed {
    logic                 compressor_drive;
    logic                 heater_drive;
    logic                 evap_fan_drive;
    logic                 cond_fan_drive;
    logic                 hot_gas_drive;
    logic                 compressor_state;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } rra_out_t;

  // State and settings that the arbitration logic looks at.
  typedef struct packed {
    logic                 comp_tracked;
    logic [ELAPSED_W-1:0] elapsed;
    logic [ELAPSED_W-1:0] min_off_ms;
    logic [ELAPSED_W-1:0] min_on_ms;
  } rra_arb_ctx_t;

endpackage

// ----- src/rra_arbiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rra_arbiter: relay decision logic
// Forms the next five-relay decision from one tick beat: lockout, source
// select, minimum on/off time hold and heater interlocks.
// ----------------------------------------------------------------------------
module rra_arbiter (
  input  rra_pkg::rra_in_t        item,
  input  rra_pkg::rra_arb_ctx_t   ctx,
  output logic [rra_pkg::DEC_W-1:0] decision
);
  import rra_pkg::*;

  logic [DEC_W-1:0] src;
  logic [DEC_W-1:0] held;
  logic             off_short;
  logic             on_short;

  // Pick the defrost or thermostat requests; thermostat leaves heater and valve off.
  always_comb begin
    if (item.defrost_mode) begin
      src = item.defrost_requests;
    end else begin
      src             = '0;
      src[BIT_COMP]   = item.therm_requests[0];
      src[BIT_EVAP]   = item.therm_requests[1];
      src[BIT_COND]   = item.therm_requests[2];
    end
  end

  assign off_short = ctx.elapsed < ctx.min_off_ms;
  assign on_short  = ctx.elapsed < ctx.min_on_ms;

  // Hold the compressor where it is until the minimum time has run out.
  always_comb begin
    held = src;
    if (src[BIT_COMP] != ctx.comp_tracked) begin
      if (src[BIT_COMP]) begin
        if (off_short) begin
          held[BIT_COMP] = 1'b0;
        end
      end else if (on_short) begin
        held[BIT_COMP] = 1'b1;
      end
    end
  end

  // Lockout clears everything; a running heater forces compressor and valve off.
  always_comb begin
    decision = held;
    if (held[BIT_HEATER]) begin
      decision[BIT_COMP] = 1'b0;
      decision[BIT_HGAS] = 1'b0;
    end
    if (item.lockout_req) begin
      decision = '0;
    end
  end

endmodule

// ----- src/refrigeration_relay_arbiter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refrigeration_relay_arbiter_top: compressor anti-short-cycle relay interlock
// Input register, one pass of decision and timer logic, result register.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the result side is not
// stalled and returns exactly one result beat for each, in order. A beat is
// captured in the input register at acceptance and its result appears in the
// result register at the next edge at which the result register is free.
// The rate of one beat per cycle is set by the update of the decision,
// tracked compressor state and timer registers at each processed beat. The
// drive fields of a result carry the decision formed by the previous beat; a
// safe-mode beat clears them at once. The configuration port is always ready
// and should be written only while no beat is in flight.
module refrigeration_relay_arbiter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rra_pkg::rra_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rra_pkg::rra_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rra_pkg::ELAPSED_W-1:0]  cfg_data
);
  import rra_pkg::*;

  logic                 in_valid_r;
  rra_in_t              in_r;
  logic                 out_valid_r;
  rra_out_t             out_r;
  rra_out_t             out_nxt;
  logic [ELAPSED_W-1:0] min_off_r;
  logic [ELAPSED_W-1:0] min_on_r;
  logic [DEC_W-1:0]     decision_r;
  logic [DEC_W-1:0]     decision_nxt;
  logic [DEC_W-1:0]     arb_dec;
  logic                 comp_tracked_r;
  logic                 comp_tracked_nxt;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [ELAPSED_W-1:0] elapsed_nxt;
  logic [ELAPSED_W-1:0] elapsed_adv;
  logic [ELAPSED_W:0]   sum;
  logic [DEC_W-1:0]     drives;
  logic                 advance;
  rra_arb_ctx_t         ctx;

  // Handshake: the input register moves on whenever the result register is free.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_off_r <= MIN_OFF_RST;
      min_on_r  <= MIN_ON_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MIN_OFF) begin
        min_off_r <= cfg_data;
      end else if (cfg_index == CFG_MIN_ON) begin
        min_on_r <= cfg_data;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Saturating timer advance for a tick beat.
  assign sum = {1'b0, elapsed_r} + {{(ELAPSED_W + 1 - DT_W){1'b0}}, in_r.dt_ms};

  always_comb begin
    if (in_r.op == OP_SAFE) begin
      elapsed_adv = elapsed_r;
    end else if (sum > {1'b0, ELAPSED_MAX}) begin
      elapsed_adv = ELAPSED_MAX;
    end else begin
      elapsed_adv = sum[ELAPSED_W-1:0];
    end
  end

  assign ctx.comp_tracked = comp_tracked_r;
  assign ctx.elapsed      = elapsed_adv;
  assign ctx.min_off_ms   = min_off_r;
  assign ctx.min_on_ms    = min_on_r;

  rra_arbiter u_arbiter (
    .item     (in_r),
    .ctx      (ctx),
    .decision (arb_dec)
  );

  // Next decision, applied drives and compressor tracking.
  always_comb begin
    if (in_r.op == OP_SAFE) begin
      decision_nxt = '0;
      drives       = '0;
    end else begin
      decision_nxt = arb_dec;
      drives       = decision_r;
    end
    if (in_r.comp_feedback != comp_tracked_r) begin
      elapsed_nxt      = '0;
      comp_tracked_nxt = in_r.comp_feedback;
    end else begin
      elapsed_nxt      = elapsed_adv;
      comp_tracked_nxt = comp_tracked_r;
    end
  end

  always_comb begin
    out_nxt.compressor_drive = drives[BIT_COMP];
    out_nxt.heater_drive     = drives[BIT_HEATER];
    out_nxt.evap_fan_drive   = drives[BIT_EVAP];
    out_nxt.cond_fan_drive   = drives[BIT_COND];
    out_nxt.hot_gas_drive    = drives[BIT_HGAS];
    out_nxt.compressor_state = comp_tracked_nxt;
    out_nxt.elapsed_ms       = elapsed_nxt;
  end

  // Block state, updated once per processed beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decision_r     <= '0;
      comp_tracked_r <= 1'b0;
      elapsed_r      <= '0;
    end else if (advance) begin
      decision_r     <= decision_nxt;
      comp_tracked_r <= comp_tracked_nxt;
      elapsed_r      <= elapsed_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- src/rra_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rra_checker: port-level checks for the relay arbiter
// Watches the top-level ports and flags results that break the interlock,
// the timer range or the result handshake.
// ----------------------------------------------------------------------------
module rra_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input rra_pkg::rra_out_t              out_data
);
  import rra_pkg::*;

  // No result beat is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat pending after reset");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // The published timer never passes its saturation limit.
  a_elapsed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.elapsed_ms <= ELAPSED_MAX)
    else $error("elapsed_ms above saturation limit");

  // A driven heater never runs together with the compressor or the hot gas valve.
  a_heater_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.heater_drive |->
      !out_data.compressor_drive && !out_data.hot_gas_drive)
    else $error("heater driven with compressor or hot gas valve");

  // A timer reset always coincides with a change of the tracked state, so a compressor
  // state change is published with the timer restarted.
  a_state_change_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid &&
      (out_data.compressor_state != $past(out_data.compressor_state)) |->
      out_data.elapsed_ms == '0)
    else $error("compressor state changed without timer restart");

endmodule

bind refrigeration_relay_arbiter_top rra_checker u_rra_checker (.*);

// ----- bench/refrigeration_relay_arbiter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refrigeration_relay_arbiter_top_tb: self-checking bench for the relay arbiter
// A queue-fed driver sends tick and safe-mode beats. An in-bench copy of the
// arbitration rules predicts each result beat. A monitor compares every
// result field against the oldest prediction. The minimum on and off times
// are changed between phases while the block is idle, and both sides stall
// at random in all but the last phase.
// ----------------------------------------------------------------------------
module refrigeration_relay_arbiter_top_tb;
  import rra_pkg::*;

  localparam int                   STALL_LIMIT      = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_MIN_ON + CFG_IDX_W'(1);

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  rra_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rra_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ELAPSED_W-1:0] cfg_data  = '0;

  // Beats waiting to be sent and results still owed by the block.
  rra_in_t  beat_backlog[$];
  rra_out_t expected_relays[$];

  // Predicted block state and register settings.
  logic [DEC_W-1:0]     relay_decision = '0;
  logic                 comp_on        = 1'b0;
  logic [ELAPSED_W-1:0] comp_timer     = '0;
  logic [ELAPSED_W-1:0] lim_off        = MIN_OFF_RST;
  logic [ELAPSED_W-1:0] lim_on         = MIN_ON_RST;

  // Stall percentages and the feedback level that random beats report.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        gen_feedback  = 1'b0;

  int unsigned fault_count  = 0;
  int unsigned n_ticks      = 0;
  int unsigned n_safe       = 0;
  int unsigned n_results    = 0;
  int unsigned n_cfg        = 0;
  int unsigned n_blocked    = 0;
  int unsigned n_interlock  = 0;
  int unsigned stall_cycles = 0;

  refrigeration_relay_arbiter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the predicted state by one beat and return the result it causes.
  function automatic rra_out_t arbitrate_relays(input rra_in_t b);
    rra_out_t             r;
    logic [DEC_W-1:0]     drives;
    logic [DEC_W-1:0]     d;
    logic [ELAPSED_W:0]   sum;
    drives = '0;
    if (b.op == OP_SAFE) begin
      relay_decision = '0;
    end else begin
      sum        = {1'b0, comp_timer} + {{(ELAPSED_W + 1 - DT_W){1'b0}}, b.dt_ms};
      comp_timer = (sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
      drives     = relay_decision;
      if (b.lockout_req) begin
        d = '0;
      end else begin
        if (b.defrost_mode) begin
          d = b.defrost_requests;
        end else begin
          d           = '0;
          d[BIT_COMP] = b.therm_requests[0];
          d[BIT_EVAP] = b.therm_requests[1];
          d[BIT_COND] = b.therm_requests[2];
        end
        // Anti-short-cycle: a compressor change waits out the minimum time.
        if (d[BIT_COMP] != comp_on) begin
          if (d[BIT_COMP] && comp_timer < lim_off) begin
            d[BIT_COMP] = 1'b0;
            n_blocked++;
          end else if (!d[BIT_COMP] && comp_timer < lim_on) begin
            d[BIT_COMP] = 1'b1;
            n_blocked++;
          end
        end
        // A running heater excludes the compressor and the hot gas valve.
        if (d[BIT_HEATER]) begin
          if (d[BIT_COMP] || d[BIT_HGAS]) n_interlock++;
          d[BIT_COMP] = 1'b0;
          d[BIT_HGAS] = 1'b0;
        end
      end
      relay_decision = d;
    end
    // Any feedback change restarts the timer, safe mode included.
    if (b.comp_feedback != comp_on) begin
      comp_timer = '0;
      comp_on    = b.comp_feedback;
    end
    r.compressor_drive = drives[BIT_COMP];
    r.heater_drive     = drives[BIT_HEATER];
    r.evap_fan_drive   = drives[BIT_EVAP];
    r.cond_fan_drive   = drives[BIT_COND];
    r.hot_gas_drive    = drives[BIT_HGAS];
    r.compressor_state = comp_on;
    r.elapsed_ms       = comp_timer;
    return r;
  endfunction

  function automatic rra_in_t make_beat(input logic op, input int unsigned dt,
                                        input logic [2:0] therm, input logic dmode,
                                        input logic [4:0] dreq, input logic lock,
                                        input logic fb);
    rra_in_t b;
    b.op               = op;
    b.dt_ms            = dt[DT_W-1:0];
    b.therm_requests   = therm;
    b.defrost_mode     = dmode;
    b.defrost_requests = dreq;
    b.lockout_req      = lock;
    b.comp_feedback    = fb;
    return b;
  endfunction

  // Random beat. The feedback level persists and flips now and then, so the
  // timer has time to run past the minimum times between changes.
  function automatic rra_in_t random_relay_beat();
    rra_in_t b;
    b.op = ($urandom_range(0, 19) == 0) ? OP_SAFE : OP_TICK;
    case ($urandom_range(0, 19))
      0:       b.dt_ms = '0;
      1, 2:    b.dt_ms = '1;
      3, 4, 5: b.dt_ms = DT_W'($urandom_range(0, 255));
      default: b.dt_ms = DT_W'($urandom_range(0, 65535));
    endcase
    b.therm_requests   = 3'($urandom_range(0, 7));
    b.defrost_mode     = ($urandom_range(0, 9) < 4);
    b.defrost_requests = 5'($urandom_range(0, 31));
    b.lockout_req      = ($urandom_range(0, 11) == 0);
    if ($urandom_range(0, 7) == 0) gen_feedback = ~gen_feedback;
    b.comp_feedback = gen_feedback;
    return b;
  endfunction

  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      report_fault($sformatf("result %0d: %s expected %0d, got %0d",
                             n_results, name, want, got));
    end
  endfunction

  // Wait at falling edges until no beat is queued, offered or owed.
  task automatic drain_pipeline();
    do @(negedge clk);
    while (beat_backlog.size() != 0 || in_valid || expected_relays.size() != 0);
  endtask

  // Register write; the predicted settings follow at the accepting edge.
  task automatic write_setpoint(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ELAPSED_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_OFF) lim_off = val;
    else if (idx == CFG_MIN_ON) lim_on = val;
    n_cfg++;
  endtask

  // One random phase; halfway through the sender holds until all results are in.
  task automatic run_random_phase(input int unsigned count, input int unsigned send_pct,
                                  input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      beat_backlog.push_back(random_relay_beat());
      if (i == count / 2) drain_pipeline();
    end
    drain_pipeline();
  endtask

  // Driver: predicts each accepted beat and offers the next one from the backlog.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_relays.push_back(arbitrate_relays(in_data));
        if (in_data.op == OP_SAFE) n_safe++;
        else n_ticks++;
      end
      if (!in_valid || in_ready) begin
        if (beat_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= beat_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls the result side at random.
  always @(posedge clk) begin : result_check
    rra_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_relays.size() == 0) begin
        report_fault($sformatf("unexpected result beat: state %0d elapsed %0d",
                               out_data.compressor_state, out_data.elapsed_ms));
      end else begin
        want = expected_relays.pop_front();
        check_field("compressor_drive", 32'(want.compressor_drive),
                    32'(out_data.compressor_drive));
        check_field("heater_drive", 32'(want.heater_drive), 32'(out_data.heater_drive));
        check_field("evap_fan_drive", 32'(want.evap_fan_drive),
                    32'(out_data.evap_fan_drive));
        check_field("cond_fan_drive", 32'(want.cond_fan_drive),
                    32'(out_data.cond_fan_drive));
        check_field("hot_gas_drive", 32'(want.hot_gas_drive), 32'(out_data.hot_gas_drive));
        check_field("compressor_state", 32'(want.compressor_state),
                    32'(out_data.compressor_state));
        check_field("elapsed_ms", 32'(want.elapsed_ms), 32'(out_data.elapsed_ms));
      end
      n_results++;
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: ends the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("refrigeration_relay_arbiter_top_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset settings.
    send_idle_pct = 32;
    recv_idle_pct = 59;
    beat_backlog.push_back(make_beat(OP_TICK, 0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b0));
    // Long compressor-off stretch: start is held back, then allowed, then
    // the timer saturates.
    for (int i = 0; i < 16; i++) begin
      beat_backlog.push_back(make_beat(OP_TICK, 65535, 3'd7, 1'b0, 5'd0, 1'b0, 1'b0));
    end
    // Defrost with every request: heater wins over compressor and hot gas.
    beat_backlog.push_back(make_beat(OP_TICK, 65535, 3'd0, 1'b1, 5'h1f, 1'b0, 1'b0));
    // Defrost without heater; feedback turns on and restarts the timer.
    beat_backlog.push_back(make_beat(OP_TICK, 100, 3'd0, 1'b1, 5'b11001, 1'b0, 1'b1));
    // Thermostat asks for stop too early: minimum on time keeps it running.
    beat_backlog.push_back(make_beat(OP_TICK, 1000, 3'd0, 1'b0, 5'd0, 1'b0, 1'b1));
    // Protection lockout with every request raised.
    beat_backlog.push_back(make_beat(OP_TICK, 65535, 3'd7, 1'b1, 5'h1f, 1'b1, 1'b1));
    // Safe mode ignores time and requests but still follows the feedback.
    beat_backlog.push_back(make_beat(OP_SAFE, 65535, 3'd7, 1'b1, 5'h1f, 1'b1, 1'b0));
    // Start request right after a stop: minimum off time blocks it.
    beat_backlog.push_back(make_beat(OP_TICK, 5, 3'd1, 1'b0, 5'd0, 1'b0, 1'b0));
    beat_backlog.push_back(make_beat(OP_TICK, 0, 3'd0, 1'b1, 5'b00011, 1'b0, 1'b0));
    beat_backlog.push_back(make_beat(OP_TICK, 0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b0));
    drain_pipeline();

    // No minimum times; a write past the register list must change nothing.
    write_setpoint(CFG_MIN_OFF, '0);
    write_setpoint(CFG_MIN_ON, '0);
    write_setpoint(CFG_FIRST_UNUSED, '1);
    run_random_phase(208, 32, 59);

    // Moderate minimum times and a random out-of-range write.
    write_setpoint(CFG_MIN_OFF, ELAPSED_W'($urandom_range(1000, 200000)));
    write_setpoint(CFG_MIN_ON, ELAPSED_W'($urandom_range(1000, 200000)));
    write_setpoint(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 255)),
                   ELAPSED_W'($urandom_range(0, 1048575)));
    run_random_phase(208, 32, 59);

    // Off time beyond the timer range never expires; on time at saturation.
    write_setpoint(CFG_MIN_OFF, '1);
    write_setpoint(CFG_MIN_ON, ELAPSED_MAX);
    run_random_phase(208, 59, 32);

    // On time beyond the timer range, off time moderate, no stalls.
    write_setpoint(CFG_MIN_OFF, ELAPSED_W'($urandom_range(0, 300000)));
    write_setpoint(CFG_MIN_ON, '1);
    run_random_phase(208, 0, 0);

    // Allow for stray result beats after the last expected one.
    repeat (16) @(posedge clk);
    fault_count += expected_relays.size();

    $display("%0d tick and %0d safe-mode beats, %0d results checked, %0d register writes",
             n_ticks, n_safe, n_results, n_cfg);
    $display("%0d compressor changes held by minimum times, %0d heater interlocks hit",
             n_blocked, n_interlock);
    if (fault_count == 0) begin
      $display("refrigeration_relay_arbiter_top_tb: done, clean");
    end else begin
      $display("%0d faults found", fault_count);
      $display("refrigeration_relay_arbiter_top_tb: done, errors");
    end
    $finish;
  end

endmodule
